### rtl/core/pwdc_pkg.sv
`default_nettype none

package pwdc_pkg;

    // Event codes carried in the input tuser field.
    localparam logic [3:0] OP_TICK        = 4'd0;
    localparam logic [3:0] OP_UP          = 4'd1;
    localparam logic [3:0] OP_DOWN        = 4'd2;
    localparam logic [3:0] OP_LOCK        = 4'd3;
    localparam logic [3:0] OP_UNLOCK      = 4'd4;
    localparam logic [3:0] OP_OPEN        = 4'd5;
    localparam logic [3:0] OP_CLOSE       = 4'd6;
    localparam logic [3:0] OP_WIN_BOTTOM  = 4'd7;
    localparam logic [3:0] OP_WIN_TOP     = 4'd8;
    localparam logic [3:0] OP_DOOR_OPEN   = 4'd9;
    localparam logic [3:0] OP_DOOR_CLOSED = 4'd10;

    localparam int          OP_W            = 4;
    localparam int          HOLD_W          = 8;
    localparam int          OUT_W           = 8;
    localparam logic [7:0]  AUTO_HOLD_RESET = 8'd40;

    // One registered input event.
    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            up_level;
        logic            down_level;
    } t_event;

    // Controller state.
    typedef struct packed {
        logic              up_drive;
        logic              down_drive;
        logic              open_drive;
        logic              close_drive;
        logic              going_up;
        logic              going_down;
        logic              auto_up;
        logic              auto_down;
        logic              locked;
        logic [HOLD_W-1:0] up_hold;
        logic [HOLD_W-1:0] down_hold;
    } t_state;

    // One result beat, before packing onto the output bus.
    typedef struct packed {
        logic auto_down_active;
        logic auto_up_active;
        logic is_locked;
        logic latch_release;
        logic door_close_drive;
        logic door_open_drive;
        logic window_down_drive;
        logic window_up_drive;
    } t_result;

endpackage

`default_nettype wire

### rtl/core/pwdc_in_reg.sv
`default_nettype none

module pwdc_in_reg (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_valid,
    output logic                  o_ready,
    input  wire  [pwdc_pkg::OP_W-1:0] i_op,
    input  wire                   i_up_level,
    input  wire                   i_down_level,
    input  wire                   i_out_full,
    input  wire                   i_out_taken,
    output logic                  o_advance,
    output pwdc_pkg::t_event      o_event
);
    import pwdc_pkg::*;

    logic   r_valid;
    logic   n_valid;
    t_event r_event;
    logic   w_load;

    // The held event moves on when the result register has room.
    assign o_advance = r_valid && (!i_out_full || i_out_taken);
    assign o_ready   = !r_valid || o_advance;
    assign w_load    = i_valid && o_ready;
    assign o_event   = r_event;

    always_comb begin
        n_valid = r_valid;
        if (w_load) begin
            n_valid = 1'b1;
        end else if (o_advance) begin
            n_valid = 1'b0;
        end
    end

    // Valid flag is control state and is reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // Payload capture needs no reset.
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_event.op         <= i_op;
            r_event.up_level   <= i_up_level;
            r_event.down_level <= i_down_level;
        end
    end

endmodule

`default_nettype wire

### rtl/core/pwdc_ctrl.sv
`default_nettype none

module pwdc_ctrl (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         i_cfg_wr_en,
    input  wire  [pwdc_pkg::HOLD_W-1:0] i_cfg_wr_data,
    input  wire                         i_advance,
    input  wire  pwdc_pkg::t_event      i_event,
    output pwdc_pkg::t_result           o_result
);
    import pwdc_pkg::*;

    t_state            r_state;
    t_state            n_state;
    logic [HOLD_W-1:0] r_hold_ticks;
    logic [HOLD_W-1:0] w_up_inc;
    logic [HOLD_W-1:0] w_down_inc;
    logic              w_latch;
    logic              w_door_busy;

    assign w_up_inc    = r_state.up_hold + 1'b1;
    assign w_down_inc  = r_state.down_hold + 1'b1;
    assign w_door_busy = r_state.open_drive || r_state.close_drive;

    // Event decode and next state.
    always_comb begin
        n_state = r_state;
        w_latch = 1'b0;
        case (i_event.op)
            OP_TICK: begin
                if (r_state.going_up && !r_state.going_down) begin
                    n_state.up_hold = w_up_inc;
                end else if (r_state.going_up == r_state.going_down) begin
                    n_state.up_hold = '0;
                end
                if (!r_state.going_up && r_state.going_down) begin
                    n_state.down_hold = w_down_inc;
                end else if (r_state.going_up == r_state.going_down) begin
                    n_state.down_hold = '0;
                end
                if (n_state.up_hold == r_hold_ticks) begin
                    n_state.up_hold = '0;
                    n_state.auto_up = 1'b1;
                end
                if (n_state.down_hold == r_hold_ticks) begin
                    n_state.down_hold = '0;
                    n_state.auto_down = 1'b1;
                end
            end
            OP_UP: begin
                if (!w_door_busy) begin
                    if (r_state.going_up && !r_state.auto_up) begin
                        n_state.going_up = 1'b0;
                        n_state.up_drive = 1'b0;
                    end else if (!r_state.going_up && !r_state.going_down) begin
                        n_state.going_up = 1'b1;
                        n_state.up_drive = 1'b1;
                    end else if (r_state.auto_down) begin
                        n_state.going_up   = 1'b1;
                        n_state.down_drive = 1'b0;
                        n_state.auto_down  = 1'b0;
                        n_state.going_down = i_event.down_level;
                    end else if (!r_state.going_up && r_state.going_down) begin
                        n_state.going_up   = 1'b1;
                        n_state.down_drive = 1'b0;
                    end
                end
            end
            OP_DOWN: begin
                if (!w_door_busy) begin
                    if (r_state.going_down && !r_state.auto_down) begin
                        n_state.going_down = 1'b0;
                        n_state.down_drive = 1'b0;
                    end else if (!r_state.going_down && !r_state.going_up) begin
                        n_state.going_down = 1'b1;
                        n_state.down_drive = 1'b1;
                    end else if (r_state.auto_up) begin
                        n_state.going_down = 1'b1;
                        n_state.up_drive   = 1'b0;
                        n_state.auto_up    = 1'b0;
                        n_state.going_up   = i_event.up_level;
                    end else if (!r_state.going_down && r_state.going_up) begin
                        n_state.going_down = 1'b1;
                        n_state.up_drive   = 1'b0;
                    end
                end
            end
            OP_LOCK: begin
                n_state.open_drive  = 1'b0;
                n_state.close_drive = 1'b1;
                n_state.locked      = 1'b1;
            end
            OP_UNLOCK: begin
                n_state.locked = 1'b0;
            end
            OP_OPEN: begin
                if (!r_state.up_drive && !r_state.down_drive && !r_state.locked) begin
                    n_state.close_drive = 1'b0;
                    n_state.open_drive  = 1'b1;
                    w_latch             = 1'b1;
                end
            end
            OP_CLOSE: begin
                if (!r_state.up_drive && !r_state.down_drive) begin
                    n_state.open_drive  = 1'b0;
                    n_state.close_drive = 1'b1;
                end
            end
            OP_WIN_BOTTOM: begin
                n_state.down_drive = 1'b0;
                n_state.auto_down  = 1'b0;
                n_state.going_down = 1'b0;
            end
            OP_WIN_TOP: begin
                n_state.up_drive = 1'b0;
                n_state.auto_up  = 1'b0;
                n_state.going_up = 1'b0;
            end
            OP_DOOR_OPEN: begin
                n_state.open_drive = 1'b0;
            end
            OP_DOOR_CLOSED: begin
                n_state.close_drive = 1'b0;
            end
            default: begin
                n_state = r_state;
            end
        endcase
    end

    // Result fields show the state after this event.
    always_comb begin
        o_result.window_up_drive   = n_state.up_drive;
        o_result.window_down_drive = n_state.down_drive;
        o_result.door_open_drive   = n_state.open_drive;
        o_result.door_close_drive  = n_state.close_drive;
        o_result.latch_release     = w_latch;
        o_result.is_locked         = n_state.locked;
        o_result.auto_up_active    = n_state.auto_up;
        o_result.auto_down_active  = n_state.auto_down;
    end

    // State commits only when the event moves into the result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= '0;
            r_hold_ticks <= AUTO_HOLD_RESET;
        end else begin
            if (i_advance) begin
                r_state <= n_state;
            end
            if (i_cfg_wr_en) begin
                r_hold_ticks <= i_cfg_wr_data;
            end
        end
    end

endmodule

`default_nettype wire

### rtl/core/pwdc_out_reg.sv
`default_nettype none

module pwdc_out_reg (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire                        i_load,
    input  wire  pwdc_pkg::t_result    i_result,
    input  wire                        i_ready,
    output logic                       o_valid,
    output logic                       o_taken,
    output logic [pwdc_pkg::OUT_W-1:0] o_data
);
    import pwdc_pkg::*;

    logic    r_valid;
    logic    n_valid;
    t_result r_result;

    assign o_valid = r_valid;
    assign o_taken = r_valid && i_ready;
    assign o_data  = r_result;

    always_comb begin
        n_valid = r_valid;
        if (i_load) begin
            n_valid = 1'b1;
        end else if (o_taken) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // Result beat holds while the receiver stalls.
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

endmodule

`default_nettype wire

### rtl/core/power_window_door_controller.sv
// Door and power window controller, one event per input beat.
// Input stream: s_axis_tuser carries the event code (tick, window buttons,
// lock, unlock, open, close, window and door end switches), s_axis_tdata
// carries the current up and down button levels.
// Output stream: one result beat per event with the four motor drives,
// the latch release pulse, the lock flag and the two one-touch flags.
// Configuration: i_cfg_wr_en writes i_cfg_wr_data as the number of ticks
// a window button must be held before one-touch mode engages (reset 40).
// Pipeline: two register stages, the input register and the result register;
// a beat moves on from the first to the second when the result register has room.
// Throughput: one beat per cycle while the receiver takes results; the event
// logic between the two registers is a single pass of flag updates.
// Reset clears all drives, flags, hold counters and both valid flags.
// When the receiver stalls, the result register holds, the input register
// takes one more beat, and then s_axis_tready drops until the result drains.
`default_nettype none

module power_window_door_controller (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_cfg_wr_en,
    input  wire  [7:0] i_cfg_wr_data,
    input  wire        s_axis_tvalid,
    output logic       s_axis_tready,
    input  wire  [7:0] s_axis_tdata,  // [0] up_button_level, [1] down_button_level, [7:2] zero
    input  wire  [3:0] s_axis_tuser,  // [3:0] op
    output logic       m_axis_tvalid,
    input  wire        m_axis_tready,
    output logic [7:0] m_axis_tdata   // [0] window_up_drive, [1] window_down_drive,
                                      // [2] door_open_drive, [3] door_close_drive,
                                      // [4] latch_release, [5] is_locked,
                                      // [6] auto_up_active, [7] auto_down_active
);
    import pwdc_pkg::*;

    t_event  w_event;
    t_result w_result;
    logic    w_advance;
    logic    w_out_valid;
    logic    w_out_taken;

    // Input register stage.
    pwdc_in_reg u_in_reg (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (s_axis_tvalid),
        .o_ready      (s_axis_tready),
        .i_op         (s_axis_tuser),
        .i_up_level   (s_axis_tdata[0]),
        .i_down_level (s_axis_tdata[1]),
        .i_out_full   (w_out_valid),
        .i_out_taken  (w_out_taken),
        .o_advance    (w_advance),
        .o_event      (w_event)
    );

    // Event logic and controller state.
    pwdc_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_advance     (w_advance),
        .i_event       (w_event),
        .o_result      (w_result)
    );

    // Result register stage.
    pwdc_out_reg u_out_reg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (w_advance),
        .i_result (w_result),
        .i_ready  (m_axis_tready),
        .o_valid  (w_out_valid),
        .o_taken  (w_out_taken),
        .o_data   (m_axis_tdata)
    );

    assign m_axis_tvalid = w_out_valid;

endmodule

`default_nettype wire

### rtl/core/pwdc_checker.sv
`default_nettype none

module pwdc_checker (
    input wire       i_clk,
    input wire       i_rst_n,
    input wire       m_axis_tvalid,
    input wire       m_axis_tready,
    input wire [7:0] m_axis_tdata
);

    // A stalled result beat stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
        else $error("result beat dropped while stalled");

    // Door motor is never driven both ways.
    a_door_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !(m_axis_tdata[2] && m_axis_tdata[3]))
        else $error("door open and close drives both set");

    // A latch release comes only with an unlocked door starting to open.
    a_latch_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[4]) |-> (m_axis_tdata[2] && !m_axis_tdata[5]))
        else $error("latch release without an accepted open");

    // A latch release never comes while a window motor runs.
    a_latch_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[4]) |-> !(m_axis_tdata[0] || m_axis_tdata[1]))
        else $error("latch release while window motor runs");

    // No result beat right after reset.
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

endmodule

bind power_window_door_controller pwdc_checker u_pwdc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
